>>> rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg - shared constants for the quaternion to Euler angle core
// Holds the CORDIC arctangent table, the default parameter values and the
// fixed widths of the angle fields.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 14;
  localparam int ATAN_TAB_LEN      = 25;
  localparam int QUAT_W            = 16;
  localparam int ANGLE_W           = 16;
  localparam int ACC_W             = 32;

  localparam logic [ACC_W-1:0]          ACC_PI      = 32'h8000_0000;
  localparam logic [ACC_W-1:0]          ACC_ROUND   = 32'h0000_8000;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_POS = 16'sd16384;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_NEG = -16'sd16384;

  // atan(2^-i) as a 32-bit binary angle (2^32 per turn).
  function automatic logic [ACC_W-1:0] atan_entry(input int unsigned idx);
    logic [ACC_W-1:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10680862;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/q2e_terms.sv
// ----------------------------------------------------------------------------
// q2e_terms - product and term front end
// Three register stages: component products, the five rotation terms with
// the pitch sine clamped and rounded, and the radicand of the pitch cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_terms #(
  parameter int FRAC_BITS = q2e_pkg::FRAC_BITS_DEF,
  parameter int TW        = 38
) (
  input  wire logic                          clk,
  input  wire logic [2:0]                    en,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0] quat_x,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0] quat_y,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0] quat_z,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0] quat_w,
  output logic signed [TW-1:0]               t0,
  output logic signed [TW-1:0]               t1,
  output logic signed [TW-1:0]               t3,
  output logic signed [TW-1:0]               t4,
  output logic signed [FRAC_BITS+1:0]        tf,
  output logic [2*FRAC_BITS+1:0]             radicand,
  output logic                               clamped
);
  import q2e_pkg::*;

  localparam int PW = 2 * QUAT_W;
  localparam int F  = FRAC_BITS;

  localparam logic signed [TW-1:0] ONE2   = TW'(1) <<< (2 * F);
  localparam logic signed [TW-1:0] HALF_F = TW'(1) <<< (F - 1);
  localparam logic signed [F+2:0]  ONE_F  = (F + 3)'(1) <<< F;

  logic signed [PW-1:0] xx, yy, zz, wx, yz, wy, zx, wz, xy;
  logic signed [TW-1:0] b_t0, b_t1, b_t2, b_t3, b_t4, b_t2c, b_round;
  logic signed [TW-1:0] c_t0, c_t1, c_t3, c_t4;
  logic signed [F+1:0]  c_tf;
  logic                 c_clamped, b_clamped;
  logic signed [F+2:0]  a_w, s_w;
  logic [2*F+3:0]       prod;

  function automatic logic signed [TW-1:0] ext(input logic signed [PW-1:0] v);
    return {{(TW-PW){v[PW-1]}}, v};
  endfunction

  // Stage A: nine 16x16 products.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      wx <= quat_w * quat_x;
      yz <= quat_y * quat_z;
      wy <= quat_w * quat_y;
      zx <= quat_z * quat_x;
      wz <= quat_w * quat_z;
      xy <= quat_x * quat_y;
    end
  end

  // Stage B: terms, clamp and rounding of the pitch sine.
  always_comb begin
    b_t0 = (ext(wx) + ext(yz)) <<< 1;
    b_t1 = ONE2 - ((ext(xx) + ext(yy)) <<< 1);
    b_t2 = (ext(wy) - ext(zx)) <<< 1;
    b_t3 = (ext(wz) + ext(xy)) <<< 1;
    b_t4 = ONE2 - ((ext(yy) + ext(zz)) <<< 1);
    b_clamped = 1'b0;
    b_t2c = b_t2;
    if (b_t2 > ONE2) begin
      b_t2c = ONE2;
      b_clamped = 1'b1;
    end else if (b_t2 < -ONE2) begin
      b_t2c = -ONE2;
      b_clamped = 1'b1;
    end
    b_round = (b_t2c + HALF_F) >>> F;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c_t0      <= b_t0;
      c_t1      <= b_t1;
      c_t3      <= b_t3;
      c_t4      <= b_t4;
      c_tf      <= b_round[F+1:0];
      c_clamped <= b_clamped;
    end
  end

  // Stage C: (1 - t)(1 + t) for the cosine.
  always_comb begin
    a_w  = ONE_F - {c_tf[F+1], c_tf};
    s_w  = ONE_F + {c_tf[F+1], c_tf};
    prod = {{(F+2){1'b0}}, a_w[F+1:0]} * {{(F+2){1'b0}}, s_w[F+1:0]};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t0       <= c_t0;
      t1       <= c_t1;
      t3       <= c_t3;
      t4       <= c_t4;
      tf       <= c_tf;
      radicand <= prod[2*F+1:0];
      clamped  <= c_clamped;
    end
  end

endmodule

`default_nettype wire

>>> rtl/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_cell - one digit of the integer square root
// Settles one result bit against the trial value root_in + 4^K and
// registers the remainder and partial root for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt_cell #(
  parameter int NW = 30,
  parameter int K  = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] rem_in,
  input  wire logic [NW-1:0] root_in,
  output logic [NW-1:0]      rem_out,
  output logic [NW-1:0]      root_out
);

  localparam logic [NW-1:0] BIT = NW'(1) << (2 * K);

  logic [NW-1:0] trial;

  assign trial = root_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out  <= rem_in - trial;
        root_out <= (root_in >> 1) + BIT;
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in >> 1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell - one vectoring CORDIC stage
// Rotates the vector towards the x axis by atan(2^-STAGE) and books the
// rotation in the angle accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell #(
  parameter int W     = 38,
  parameter int STAGE = 0
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [W-1:0]           x_in,
  input  wire logic signed [W-1:0]           y_in,
  input  wire logic [q2e_pkg::ACC_W-1:0]     acc_in,
  output logic signed [W-1:0]                x_out,
  output logic signed [W-1:0]                y_out,
  output logic [q2e_pkg::ACC_W-1:0]          acc_out
);
  import q2e_pkg::*;

  localparam logic [ACC_W-1:0] STEP = atan_entry(STAGE);

  logic signed [W-1:0] dx, dy;

  assign dx = x_in >>> STAGE;
  assign dy = y_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[W-1]) begin
        x_out   <= x_in + dy;
        y_out   <= y_in - dx;
        acc_out <= acc_in + STEP;
      end else begin
        x_out   <= x_in - dy;
        y_out   <= y_in + dx;
        acc_out <= acc_in - STEP;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/quaternion_to_euler_angles_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core - unit quaternion to ZYX roll, pitch, yaw
// Fully pipelined: product front end, a chain of square-root cells for the
// pitch cosine, and three parallel chains of vectoring CORDIC cells.
// ----------------------------------------------------------------------------
// Usage
//   One quaternion enters per transfer on the s_ channel, packed x, y, z, w
//   from the lowest bit up, each signed with FRAC_BITS fraction bits. One
//   result leaves per transfer on the m_ channel: roll, pitch and yaw as
//   16-bit binary angles (32768 stands for pi) in m_tdata, and in m_tuser a
//   flag that is set when the pitch sine had to be clamped to plus or minus
//   one.
//   An input passes through the three front-end stages, the FRAC_BITS + 1
//   square-root cells, one CORDIC set-up stage, the CORDIC cells and the
//   output register. Throughput is one quaternion per clock while the
//   receiver does not stall.
//   Every stage has its own valid bit and moves forward whenever the stage
//   after it is empty or moving, so bubbles close up. When the receiver
//   stalls, the pipeline keeps taking input until every stage is full; only
//   then does s_tready fall.
//   Reset (rst, synchronous, active high) empties the pipeline; no result is
//   held over. There is no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = q2e_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic             m_tuser    // pitch_clamped
);
  import q2e_pkg::*;

  localparam int F  = FRAC_BITS;
  // Stages beyond the arctangent table are not run.
  localparam int NS = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;
  // Term width: products carry 2F fraction bits, the CORDIC gain needs headroom.
  localparam int TW = ((2 * F > 34) ? 2 * F : 34) + 4;
  localparam int NW = 2 * F + 2;
  localparam int SQ = F + 1;              // square-root cells
  localparam int PREP = 3 + SQ;           // stage index of the CORDIC set-up
  localparam int D  = PREP + NS + 2;      // total pipeline stages

  logic [D-1:0] v;
  logic [D-1:0] en;

  // Stage k may load when it is empty or its content moves on.
  assign en[D-1] = !v[D-1] || m_tready;
  for (genvar k = 0; k < D - 1; k++) begin : g_adv
    assign en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int k = 1; k < D; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[D-1];

  // Front end.
  logic signed [TW-1:0] f_t0, f_t1, f_t3, f_t4;
  logic signed [F+1:0]  f_tf;
  logic [NW-1:0]        f_rad;
  logic                 f_clamped;

  q2e_terms #(.FRAC_BITS(F), .TW(TW)) u_terms (
    .clk      (clk),
    .en       (en[2:0]),
    .quat_x   (s_tdata[15:0]),
    .quat_y   (s_tdata[31:16]),
    .quat_z   (s_tdata[47:32]),
    .quat_w   (s_tdata[63:48]),
    .t0       (f_t0),
    .t1       (f_t1),
    .t3       (f_t3),
    .t4       (f_t4),
    .tf       (f_tf),
    .radicand (f_rad),
    .clamped  (f_clamped)
  );

  // Square-root chain, with the other terms riding alongside in a delay line.
  logic [NW-1:0]        sq_rem  [SQ+1];
  logic [NW-1:0]        sq_root [SQ+1];
  logic signed [TW-1:0] d_t0 [SQ], d_t1 [SQ], d_t3 [SQ], d_t4 [SQ];
  logic signed [F+1:0]  d_tf [SQ];
  logic                 d_cl [SQ];

  assign sq_rem[0]  = f_rad;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    q2e_sqrt_cell #(.NW(NW), .K(F - j)) u_cell (
      .clk      (clk),
      .en       (en[3+j]),
      .rem_in   (sq_rem[j]),
      .root_in  (sq_root[j]),
      .rem_out  (sq_rem[j+1]),
      .root_out (sq_root[j+1])
    );

    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[3]) begin
          d_t0[0] <= f_t0;
          d_t1[0] <= f_t1;
          d_t3[0] <= f_t3;
          d_t4[0] <= f_t4;
          d_tf[0] <= f_tf;
          d_cl[0] <= f_clamped;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[3+j]) begin
          d_t0[j] <= d_t0[j-1];
          d_t1[j] <= d_t1[j-1];
          d_t3[j] <= d_t3[j-1];
          d_t4[j] <= d_t4[j-1];
          d_tf[j] <= d_tf[j-1];
          d_cl[j] <= d_cl[j-1];
        end
      end
    end
  end

  // CORDIC set-up: chain 0 roll, chain 1 pitch, chain 2 yaw. A vector in the
  // left half plane is mirrored and its angle starts at pi.
  logic signed [TW-1:0] pre_x [3], pre_y [3];
  logic signed [TW-1:0] cx [3][NS+1];
  logic signed [TW-1:0] cy [3][NS+1];
  logic [ACC_W-1:0]     ca [3][NS+1];
  logic                 c_cl [NS+1];

  assign pre_y[0] = d_t0[SQ-1];
  assign pre_x[0] = d_t1[SQ-1];
  assign pre_y[1] = {{(TW-F-2){d_tf[SQ-1][F+1]}}, d_tf[SQ-1]};
  assign pre_x[1] = TW'(sq_root[SQ]);
  assign pre_y[2] = d_t3[SQ-1];
  assign pre_x[2] = d_t4[SQ-1];

  for (genvar c = 0; c < 3; c++) begin : g_prep
    always_ff @(posedge clk) begin
      if (en[PREP]) begin
        if (pre_x[c][TW-1]) begin
          cx[c][0] <= -pre_x[c];
          cy[c][0] <= -pre_y[c];
          ca[c][0] <= ACC_PI;
        end else begin
          cx[c][0] <= pre_x[c];
          cy[c][0] <= pre_y[c];
          ca[c][0] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[PREP]) c_cl[0] <= d_cl[SQ-1];
  end

  for (genvar c = 0; c < 3; c++) begin : g_chain
    for (genvar i = 0; i < NS; i++) begin : g_stage
      q2e_cordic_cell #(.W(TW), .STAGE(i)) u_cell (
        .clk     (clk),
        .en      (en[PREP+1+i]),
        .x_in    (cx[c][i]),
        .y_in    (cy[c][i]),
        .acc_in  (ca[c][i]),
        .x_out   (cx[c][i+1]),
        .y_out   (cy[c][i+1]),
        .acc_out (ca[c][i+1])
      );
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_flag
    always_ff @(posedge clk) begin
      if (en[PREP+1+i]) c_cl[i+1] <= c_cl[i];
    end
  end

  // Output register: round the 32-bit angles to 16 bits and limit pitch.
  logic [ACC_W-1:0]            r_roll, r_pitch, r_yaw;
  logic signed [ANGLE_W-1:0]   pv, pv_lim;
  logic signed [ANGLE_W-1:0]   roll_angle, pitch_angle, yaw_angle;
  logic                        pitch_clamped;

  always_comb begin
    r_roll  = ca[0][NS] + ACC_ROUND;
    r_pitch = ca[1][NS] + ACC_ROUND;
    r_yaw   = ca[2][NS] + ACC_ROUND;
    pv      = r_pitch[ACC_W-1:ACC_W-ANGLE_W];
    pv_lim  = pv;
    if (pv > HALF_PI_POS) pv_lim = HALF_PI_POS;
    if (pv < HALF_PI_NEG) pv_lim = HALF_PI_NEG;
  end

  always_ff @(posedge clk) begin
    if (en[D-1]) begin
      roll_angle    <= r_roll[ACC_W-1:ACC_W-ANGLE_W];
      pitch_angle   <= pv_lim;
      yaw_angle     <= r_yaw[ACC_W-1:ACC_W-ANGLE_W];
      pitch_clamped <= c_cl[NS];
    end
  end

  assign m_tdata = {yaw_angle, pitch_angle, roll_angle};
  assign m_tuser = pitch_clamped;

`ifndef ASSERT_OFF
  // An empty output stage means the whole pipeline can move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage empty");

  // Pitch never leaves the quarter turn either side of level.
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pitch_angle <= HALF_PI_POS) && (pitch_angle >= HALF_PI_NEG))
    else $error("pitch out of range");

  // The cosine root never exceeds one.
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    v[PREP-1] |-> (sq_root[SQ] <= (NW'(1) << F)))
    else $error("cosine root above one");

  // The CORDIC set-up stage, holding an item and not allowed to move, still holds one.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v[PREP] && !en[PREP]) |=> v[PREP])
    else $error("item lost in a stalled stage");
`endif

endmodule

`default_nettype wire
